FILE: hdl/trmrs_pkg.sv
`timescale 1ns / 1ps

package trmrs_pkg;

  localparam int NUM_DIMS        = 3;
  localparam int ADDR_W          = 12;
  localparam int COORD_W         = 5;
  localparam int SIZE_W          = 5;
  localparam int PORT_W          = 3;
  localparam int MASK_W          = 2 * NUM_DIMS;
  localparam int START_W         = 3;
  localparam int QUEUE_W         = 2;
  localparam int COUNT_W         = 2;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 12;
  localparam int STEPS_PER_STAGE = 4;
  localparam int STAGES_PER_DIM  = ADDR_W / STEPS_PER_STAGE;
  localparam int DIV_STAGES      = NUM_DIMS * STAGES_PER_DIM;

  localparam logic [QUEUE_W-1:0] QUEUE_A = 2'd0;
  localparam logic [QUEUE_W-1:0] QUEUE_B = 2'd1;
  localparam logic [QUEUE_W-1:0] QUEUE_C = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_NODE_ADDRESS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_X       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_Y       = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_Z       = 2'd3;

  typedef logic [NUM_DIMS-1:0][SIZE_W-1:0] size_vec_t;
  typedef logic [NUM_DIMS-1:0][COORD_W-1:0] coord_vec_t;

  typedef struct packed {
    logic [COORD_W-1:0] r;
    logic [ADDR_W-1:0]  w;
  } div_state_t;

  typedef struct packed {
    div_state_t          node;
    div_state_t          dest;
    coord_vec_t          node_c;
    coord_vec_t          dest_c;
    logic                atd;
    logic [QUEUE_W-1:0]  q;
    logic [MASK_W-1:0]   busy;
    logic [START_W-1:0]  rstart;
  } flight_t;

  typedef struct packed {
    logic                             atd;
    logic [MASK_W-1:0]                mask;
    logic [QUEUE_W-1:0]               q;
    logic [QUEUE_W-1:0]               nq;
    logic [COUNT_W-1:0]               n;
    logic [NUM_DIMS-1:0][PORT_W-1:0]  ports;
    logic [COUNT_W-1:0]               start;
    logic [MASK_W-1:0]                busy;
  } decision_t;

  typedef struct packed {
    logic               at_destination;
    logic [MASK_W-1:0]  dir_mask;
    logic [QUEUE_W-1:0] next_queue;
    logic               queue_change;
    logic               route_ok;
    logic [PORT_W-1:0]  out_port;
  } result_t;

  // One step of restoring division: shift in the next dividend bit and
  // replace it with the quotient bit.
  function automatic div_state_t div_step(div_state_t st, logic [SIZE_W-1:0] k);
    logic [COORD_W:0] sh;
    div_state_t       nx;
    sh = {st.r, st.w[ADDR_W-1]};
    nx.w = {st.w[ADDR_W-2:0], 1'b0};
    if (sh >= {1'b0, k}) begin
      nx.r = COORD_W'(sh - {1'b0, k});
      nx.w[0] = 1'b1;
    end else begin
      nx.r = sh[COORD_W-1:0];
    end
    return nx;
  endfunction

endpackage

FILE: hdl/trmrs_req_if.sv
`timescale 1ns / 1ps

interface trmrs_req_if;
  import trmrs_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   dest_address;
  logic [QUEUE_W-1:0]  current_queue;
  logic                injected;
  logic [MASK_W-1:0]   port_busy;
  logic [START_W-1:0]  rand_start;

  modport source (
    output valid, dest_address, current_queue, injected, port_busy, rand_start,
    input  ready
  );

  modport sink (
    input  valid, dest_address, current_queue, injected, port_busy, rand_start,
    output ready
  );
endinterface

FILE: hdl/trmrs_rsp_if.sv
`timescale 1ns / 1ps

interface trmrs_rsp_if;
  import trmrs_pkg::*;

  logic                valid;
  logic                ready;
  logic                at_destination;
  logic [MASK_W-1:0]   dir_mask;
  logic [QUEUE_W-1:0]  next_queue;
  logic                queue_change;
  logic                route_ok;
  logic [PORT_W-1:0]   out_port;

  modport source (
    output valid, at_destination, dir_mask, next_queue, queue_change, route_ok,
           out_port,
    input  ready
  );

  modport sink (
    input  valid, at_destination, dir_mask, next_queue, queue_change, route_ok,
           out_port,
    output ready
  );
endinterface

FILE: hdl/trmrs_div_stage.sv
`timescale 1ns / 1ps

module trmrs_div_stage #(
  parameter int DIM    = 0,
  parameter bit FINISH = 1'b0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  trmrs_pkg::size_vec_t  ksize,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  trmrs_pkg::flight_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output trmrs_pkg::flight_t    out_data
);
  import trmrs_pkg::*;

  flight_t nd;

  always_comb begin
    nd = in_data;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      nd.node = div_step(nd.node, ksize[DIM]);
      nd.dest = div_step(nd.dest, ksize[DIM]);
    end
    if (FINISH) begin
      nd.node_c[DIM] = nd.node.r;
      nd.dest_c[DIM] = nd.dest.r;
      nd.node.r = '0;
      nd.dest.r = '0;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= nd;
    end
  end

endmodule

FILE: hdl/trmrs_decide.sv
`timescale 1ns / 1ps

module trmrs_decide (
  input  logic                  clk,
  input  logic                  rst,
  input  trmrs_pkg::size_vec_t  ksize,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  trmrs_pkg::flight_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output trmrs_pkg::decision_t  out_data
);
  import trmrs_pkg::*;

  decision_t          nd;
  logic [COORD_W:0]   off;
  logic [COORD_W-1:0] here;
  logic [COORD_W-1:0] there;
  logic [SIZE_W-1:0]  k;
  logic               larger;
  logic               smaller;
  logic [PORT_W-1:0]  p;

  always_comb begin
    nd = '0;
    larger = 1'b0;
    smaller = 1'b0;
    off = '0;
    here = '0;
    there = '0;
    k = '0;
    p = '0;
    for (int i = 0; i < NUM_DIMS; i++) begin
      here = in_data.node_c[i];
      there = in_data.dest_c[i];
      k = ksize[i];
      if (there >= here) begin
        off = {1'b0, there} - {1'b0, here};
      end else begin
        off = {1'b0, there} + {1'b0, k} - {1'b0, here};
      end
      if (off != '0) begin
        if (off <= {2'b00, k[SIZE_W-1:1]}) begin
          p = PORT_W'(2 * i);
          if (here != k - 1'b1) larger = 1'b1;
          else smaller = 1'b1;
        end else begin
          p = PORT_W'(2 * i + 1);
          if (here == '0) larger = 1'b1;
          else smaller = 1'b1;
        end
        nd.ports[nd.n] = p;
        nd.n = nd.n + 1'b1;
        nd.mask[p] = 1'b1;
      end
    end

    nd.atd = in_data.atd;
    nd.q = in_data.q;
    nd.busy = in_data.busy;
    if (in_data.atd) begin
      nd.nq = in_data.q;
    end else if (in_data.q == QUEUE_A) begin
      nd.nq = larger ? QUEUE_A : QUEUE_B;
    end else if (in_data.q == QUEUE_B) begin
      nd.nq = smaller ? QUEUE_B : QUEUE_C;
    end else begin
      nd.nq = QUEUE_C;
    end

    case (nd.n)
      2'd2:    nd.start = {1'b0, in_data.rstart[0]};
      2'd3: begin
        case (in_data.rstart)
          3'd1, 3'd4, 3'd7: nd.start = 2'd1;
          3'd2, 3'd5:       nd.start = 2'd2;
          default:          nd.start = 2'd0;
        endcase
      end
      default: nd.start = 2'd0;
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= nd;
    end
  end

endmodule

FILE: hdl/trmrs_select.sv
`timescale 1ns / 1ps

module trmrs_select (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  trmrs_pkg::decision_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output trmrs_pkg::result_t    out_data
);
  import trmrs_pkg::*;

  result_t           nd;
  logic              stay;
  logic [PORT_W-1:0] idx;
  logic [PORT_W-1:0] p;

  always_comb begin
    nd = '0;
    idx = '0;
    p = '0;
    stay = !in_data.atd && (in_data.nq == in_data.q) && (in_data.n != '0);
    nd.at_destination = in_data.atd;
    nd.dir_mask = in_data.mask;
    nd.next_queue = in_data.nq;
    nd.queue_change = in_data.nq != in_data.q;
    for (int d = 0; d < NUM_DIMS; d++) begin
      idx = {1'b0, in_data.start} + PORT_W'(d);
      if (idx >= {1'b0, in_data.n}) idx = idx - {1'b0, in_data.n};
      p = in_data.ports[idx[COUNT_W-1:0]];
      if (stay && (COUNT_W'(d) < in_data.n) && !nd.route_ok && !in_data.busy[p]) begin
        nd.route_ok = 1'b1;
        nd.out_port = p;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= nd;
    end
  end

endmodule

FILE: hdl/torus_minimal_route_select_core.sv
`timescale 1ns / 1ps
// Pipeline: nine divider stages of four quotient bits each, a decision stage and a
// port-scan stage, each with its own output register.
// Throughput: one word per cycle; every stage holds its word when stalled and
// takes a new word as soon as it moves on.
// Reset: synchronous; clears all valid bits and loads address 0 and sizes 4.
module torus_minimal_route_select_core #(
  parameter int MAX_RADIX = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [trmrs_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [trmrs_pkg::CFG_DATA_W-1:0]       cfg_data,
  trmrs_req_if.sink                              req,
  trmrs_rsp_if.source                            rsp
);
  import trmrs_pkg::*;

  localparam logic [SIZE_W-1:0] CLAMP =
    SIZE_W'((MAX_RADIX > (2 ** SIZE_W - 1)) ? (2 ** SIZE_W - 1) : MAX_RADIX);

  logic [ADDR_W-1:0] node_address;
  size_vec_t         size_reg;
  size_vec_t         ksize;

  flight_t   stage_data  [DIV_STAGES+1];
  logic      stage_valid [DIV_STAGES+1];
  logic      stage_ready [DIV_STAGES+1];
  decision_t dec_data;
  logic      dec_valid;
  logic      dec_ready;
  result_t   res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_address <= '0;
      size_reg <= {NUM_DIMS{SIZE_W'(4)}};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NODE_ADDRESS: node_address <= cfg_data[ADDR_W-1:0];
        REG_SIZE_X:       size_reg[0] <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Y:       size_reg[1] <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Z:       size_reg[2] <= cfg_data[SIZE_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_DIMS; i++) begin
      if (size_reg[i] == '0) ksize[i] = SIZE_W'(1);
      else if (size_reg[i] > CLAMP) ksize[i] = CLAMP;
      else ksize[i] = size_reg[i];
    end
  end

  always_comb begin
    stage_data[0] = '0;
    stage_data[0].node.w = node_address;
    stage_data[0].dest.w = req.dest_address;
    stage_data[0].atd = req.dest_address == node_address;
    if (req.injected) stage_data[0].q = QUEUE_A;
    else if (req.current_queue >= QUEUE_C) stage_data[0].q = QUEUE_C;
    else stage_data[0].q = req.current_queue;
    stage_data[0].busy = req.port_busy;
    stage_data[0].rstart = req.rand_start;
  end

  assign stage_valid[0] = req.valid;
  assign req.ready = stage_ready[0];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    trmrs_div_stage #(
      .DIM    (g / STAGES_PER_DIM),
      .FINISH ((g % STAGES_PER_DIM) == (STAGES_PER_DIM - 1))
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .ksize     (ksize),
      .in_valid  (stage_valid[g]),
      .in_ready  (stage_ready[g]),
      .in_data   (stage_data[g]),
      .out_valid (stage_valid[g+1]),
      .out_ready (stage_ready[g+1]),
      .out_data  (stage_data[g+1])
    );
  end

  trmrs_decide u_decide (
    .clk       (clk),
    .rst       (rst),
    .ksize     (ksize),
    .in_valid  (stage_valid[DIV_STAGES]),
    .in_ready  (stage_ready[DIV_STAGES]),
    .in_data   (stage_data[DIV_STAGES]),
    .out_valid (dec_valid),
    .out_ready (dec_ready),
    .out_data  (dec_data)
  );

  trmrs_select u_select (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec_data),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (res_data)
  );

  assign rsp.at_destination = res_data.at_destination;
  assign rsp.dir_mask       = res_data.dir_mask;
  assign rsp.next_queue     = res_data.next_queue;
  assign rsp.queue_change   = res_data.queue_change;
  assign rsp.route_ok       = res_data.route_ok;
  assign rsp.out_port       = res_data.out_port;

  a_ok_in_mask: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.route_ok |-> rsp.dir_mask[rsp.out_port] && !rsp.queue_change
      && !rsp.at_destination)
    else $error("Chosen port is not an admissible direction.");

  a_change_no_port: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.queue_change |-> !rsp.route_ok && rsp.out_port == '0
      && rsp.next_queue != QUEUE_A)
    else $error("Queue change carries a port choice.");

  a_dest_stays: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.at_destination |-> !rsp.queue_change && !rsp.route_ok)
    else $error("Packet at its destination was routed onward.");

  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !rsp.valid && !dec_valid)
    else $error("Pipeline holds a word right after reset.");

endmodule
